[hw/rtl/set_assoc_cache_tag_store_defines.svh]
// ----------------------------------------------------------------------------
// Set-associative cache tag store: assertion macros
// Shared macros for the concurrent checks of the tag store.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SACTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag store check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SACTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tag store check failed");

`endif

[hw/rtl/sacts_pkg.sv]
// ----------------------------------------------------------------------------
// Set-associative cache tag store: package
// Shared constants, operation codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package sacts_pkg;

    localparam int DEF_MAX_SETS  = 256;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 32;

    localparam int CNT_W = 12;
    localparam int CFG_W = 4;
    localparam int IDX_W = 2;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [IDX_W-1:0] REG_SETS   = 2'd2;
    localparam logic [IDX_W-1:0] REG_WAYS   = 2'd3;

    localparam logic       RST_POLICY = 1'b0;
    localparam logic [3:0] RST_OFFSET = 4'd5;
    localparam logic [3:0] RST_SETS   = 4'd0;
    localparam logic [3:0] RST_WAYS   = 4'd8;

    typedef struct packed {
        logic accept;
        logic update;
        logic flush_step;
        logic flush_done;
    } sacts_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic last_set;
    } sacts_status_t;

endpackage

[hw/rtl/set_assoc_cache_tag_store.sv]
// ----------------------------------------------------------------------------
// Set-associative cache tag store: top level
// Tag, dirty and replacement state of a write-back, write-allocate cache.
//
// A request enters on operation/address with in_valid; it is taken at a
// clock edge where in_valid is high and in_stall is low. Each request gives
// one result on hit, way, writeback and dirty_count, taken at an edge where
// out_valid is high and out_stall is low.
// A read, write or fetch first reads the set row from the set memory, then
// compares the ways in use and writes the row back; the result is registered
// with that write-back. No new request is taken until then.
// A flush sweeps the sets in use one row a cycle.
// A finished result waits in the output register while out_stall is high;
// the next request is still taken and waits before its row write-back.
// Reset clears all line state through per-set valid bits at once, restores
// the register defaults and empties the output register; no clearing pass.
// Configuration is written through cfg_write, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store
#(
    parameter int MAX_SETS  = sacts_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = sacts_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = sacts_pkg::DEF_ADDR_BITS,
    parameter int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [sacts_pkg::IDX_W-1:0] cfg_index,
    input  logic [sacts_pkg::CFG_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [ADDR_BITS-1:0]        address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic [WAY_W-1:0]            way,
    output logic                        writeback,
    output logic [sacts_pkg::CNT_W-1:0] dirty_count
);
    import sacts_pkg::*;

    sacts_cmd_t    cmd;
    sacts_status_t status;

    sacts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sacts_datapath
    #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .WAY_W     (WAY_W)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .address     (address),
        .cmd         (cmd),
        .status      (status),
        .hit         (hit),
        .way         (way),
        .writeback   (writeback),
        .dirty_count (dirty_count)
    );

endmodule

[hw/rtl/sacts_ctrl.sv]
// ----------------------------------------------------------------------------
// Set-associative cache tag store: controller
// Sequences lookups and flush sweeps and owns the handshake state.
// ----------------------------------------------------------------------------
module sacts_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  sacts_pkg::sacts_status_t status,
    output sacts_pkg::sacts_cmd_t    cmd
);
    import sacts_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_FLUSH  = 2'd2;
    localparam logic [1:0] S_DRAIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.is_flush ? S_FLUSH : S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.flush_step = 1'b1;
                if (status.last_set)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.flush_done = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/sacts_datapath.sv]
// ----------------------------------------------------------------------------
// Set-associative cache tag store: datapath
// Configuration, set memory, way compare, replacement update and flush count.
// ----------------------------------------------------------------------------
module sacts_datapath
#(
    parameter int MAX_SETS  = sacts_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = sacts_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = sacts_pkg::DEF_ADDR_BITS,
    parameter int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [sacts_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sacts_pkg::CFG_W-1:0]   cfg_data,
    input  logic [1:0]                    operation,
    input  logic [ADDR_BITS-1:0]          address,
    input  sacts_pkg::sacts_cmd_t         cmd,
    output sacts_pkg::sacts_status_t      status,
    output logic                          hit,
    output logic [WAY_W-1:0]              way,
    output logic                          writeback,
    output logic [sacts_pkg::CNT_W-1:0]   dirty_count
);
    import sacts_pkg::*;

    localparam int SET_W     = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_IDX_W = (SET_W > 0) ? SET_W : 1;
    localparam int NW_W      = $clog2(MAX_WAYS + 1);
    localparam logic [3:0] SET_W4 = 4'(SET_W);
    localparam logic [4:0] MAX_WAYS5 = 5'(MAX_WAYS);

    logic       policy_reg;
    logic [3:0] offset_reg;
    logic [3:0] sets_reg;
    logic [3:0] ways_reg;

    logic [MAX_WAYS-1:0]                 valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]                 dirty_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  tag_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0][WAY_W-1:0]      order_mem [MAX_SETS];
    logic [WAY_W-1:0]                    fill_mem  [MAX_SETS];
    logic [MAX_SETS-1:0]                 row_ok_reg;

    logic [MAX_WAYS-1:0]                 rd_valid_reg;
    logic [MAX_WAYS-1:0]                 rd_dirty_reg;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  rd_tag_reg;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      rd_order_reg;
    logic [WAY_W-1:0]                    rd_fill_reg;
    logic                                rd_ok_reg;

    logic [1:0]            op_reg;
    logic [ADDR_BITS-1:0]  tag_reg;
    logic [SET_IDX_W-1:0]  set_reg;
    logic [SET_IDX_W-1:0]  cnt_reg;
    logic                  pend_reg;
    logic [CNT_W-1:0]      acc_reg;

    logic                  hit_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  wb_reg;
    logic [CNT_W-1:0]      count_reg;

    logic [3:0]            sb;
    logic [SET_IDX_W-1:0]  set_mask;
    logic [ADDR_BITS-1:0]  blk;
    logic [SET_IDX_W-1:0]  in_set;
    logic [ADDR_BITS-1:0]  in_tag;
    logic [NW_W-1:0]       n_ways;
    logic [MAX_WAYS-1:0]   in_use;
    logic [SET_IDX_W-1:0]  rd_addr;
    logic                  rd_en;

    logic [MAX_WAYS-1:0]                 cur_valid;
    logic [MAX_WAYS-1:0]                 cur_dirty;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      cur_order;
    logic [WAY_W-1:0]                    cur_fill;

    logic                                hit_c;
    logic [WAY_W-1:0]                    hw_c;
    logic [WAY_W-1:0]                    vw_c;
    logic                                wb_c;
    logic [MAX_WAYS-1:0]                 new_valid;
    logic [MAX_WAYS-1:0]                 new_dirty;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  new_tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      new_order;
    logic [WAY_W-1:0]                    new_fill;
    logic [CNT_W-1:0]                    row_count;

    always_comb
    begin
        logic [4:0] w5;
        w5 = {1'b0, ways_reg};
        if (ways_reg == 4'd0)
        begin
            n_ways = NW_W'(1);
        end
        else if (w5 > MAX_WAYS5)
        begin
            n_ways = NW_W'(MAX_WAYS);
        end
        else
        begin
            n_ways = NW_W'(ways_reg);
        end
    end

    assign sb       = (sets_reg > SET_W4) ? SET_W4 : sets_reg;
    assign set_mask = ~({SET_IDX_W{1'b1}} << sb);
    assign blk      = address >> offset_reg;
    assign in_set   = blk[SET_IDX_W-1:0] & set_mask;
    assign in_tag   = blk >> sb;

    always_comb
    begin
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            in_use[j] = ((NW_W + 1)'(j) < (NW_W + 1)'(n_ways));
        end
    end

    assign status.is_flush = (operation == OP_FLUSH);
    assign status.last_set = (cnt_reg == set_mask);

    assign rd_en   = cmd.accept || cmd.flush_step;
    assign rd_addr = cmd.flush_step ? cnt_reg : in_set;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= RST_POLICY;
            offset_reg <= RST_OFFSET;
            sets_reg   <= RST_SETS;
            ways_reg   <= RST_WAYS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[0];
                REG_OFFSET: offset_reg <= cfg_data;
                REG_SETS:   sets_reg   <= cfg_data;
                REG_WAYS:   ways_reg   <= cfg_data;
                default:    policy_reg <= policy_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_dirty_reg <= dirty_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_order_reg <= order_mem[rd_addr];
            rd_fill_reg  <= fill_mem[rd_addr];
        end
        if (cmd.update)
        begin
            valid_mem[set_reg] <= new_valid;
            dirty_mem[set_reg] <= new_dirty;
            tag_mem[set_reg]   <= new_tag;
            order_mem[set_reg] <= new_order;
            fill_mem[set_reg]  <= new_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_ok_reg <= row_ok_reg[rd_addr];
            end
            if (cmd.update)
            begin
                row_ok_reg[set_reg] <= 1'b1;
            end
        end
    end

    assign cur_valid = rd_ok_reg ? rd_valid_reg : '0;
    assign cur_dirty = rd_ok_reg ? rd_dirty_reg : '0;
    assign cur_order = rd_ok_reg ? rd_order_reg : '0;
    assign cur_fill  = rd_ok_reg ? rd_fill_reg  : '0;

    always_comb
    begin
        logic [WAY_W-1:0]  used;
        logic [WAY_W-1:0]  mine;
        logic              vf;
        logic              do_promote;
        logic [WAY_W:0]    fill_p1;
        hit_c = 1'b0;
        hw_c  = '0;
        vf    = 1'b0;
        vw_c  = '0;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if (!hit_c && in_use[j] && cur_valid[j] && (rd_tag_reg[j] == tag_reg))
            begin
                hit_c = 1'b1;
                hw_c  = WAY_W'(j);
            end
            if (!vf && in_use[j] && (cur_order[j] == '0))
            begin
                vf   = 1'b1;
                vw_c = WAY_W'(j);
            end
        end
        used       = hit_c ? hw_c : vw_c;
        mine       = cur_order[used];
        fill_p1    = {1'b0, cur_fill} + (WAY_W + 1)'(1);
        wb_c       = !hit_c && cur_dirty[vw_c];
        new_valid  = cur_valid;
        new_dirty  = cur_dirty;
        new_tag    = rd_ok_reg ? rd_tag_reg : '0;
        new_order  = cur_order;
        new_fill   = cur_fill;
        do_promote = 1'b0;
        if (hit_c)
        begin
            do_promote = policy_reg;
            if (op_reg == OP_WRITE)
            begin
                new_dirty[hw_c] = 1'b1;
            end
        end
        else
        begin
            new_valid[vw_c] = 1'b1;
            new_tag[vw_c]   = tag_reg;
            new_dirty[vw_c] = (op_reg == OP_WRITE);
            if ((NW_W + 1)'(fill_p1) < (NW_W + 1)'(n_ways))
            begin
                new_fill        = fill_p1[WAY_W-1:0];
                new_order[vw_c] = fill_p1[WAY_W-1:0];
            end
            else if (!policy_reg)
            begin
                for (int j = 0; j < MAX_WAYS; j++)
                begin
                    if (in_use[j] && (cur_order[j] != '0))
                    begin
                        new_order[j] = cur_order[j] - WAY_W'(1);
                    end
                end
                new_order[vw_c] = cur_fill;
            end
            else
            begin
                do_promote = 1'b1;
            end
        end
        if (do_promote)
        begin
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (in_use[j] && (cur_order[j] > mine))
                begin
                    new_order[j] = cur_order[j] - WAY_W'(1);
                end
            end
            new_order[used] = cur_fill;
        end
    end

    always_comb
    begin
        row_count = '0;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            row_count = row_count + CNT_W'(in_use[j] && cur_dirty[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            tag_reg <= in_tag;
            set_reg <= in_set;
        end
        if (cmd.update)
        begin
            hit_reg   <= hit_c;
            way_reg   <= hit_c ? hw_c : vw_c;
            wb_reg    <= wb_c;
            count_reg <= '0;
        end
        else if (cmd.flush_done)
        begin
            hit_reg   <= 1'b0;
            way_reg   <= '0;
            wb_reg    <= 1'b0;
            count_reg <= acc_reg + row_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else if (cmd.flush_step)
        begin
            cnt_reg  <= cnt_reg + SET_IDX_W'(1);
            pend_reg <= 1'b1;
            if (pend_reg)
            begin
                acc_reg <= acc_reg + row_count;
            end
        end
    end

    assign hit         = hit_reg;
    assign way         = way_reg;
    assign writeback   = wb_reg;
    assign dirty_count = count_reg;

endmodule

[hw/rtl/sacts_checker.sv]
// ----------------------------------------------------------------------------
// Set-associative cache tag store: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_store_defines.svh"

module sacts_checker
#(
    parameter int ADDR_BITS = sacts_pkg::DEF_ADDR_BITS,
    parameter int WAY_W     = 3
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_write,
    input logic [sacts_pkg::IDX_W-1:0] cfg_index,
    input logic [sacts_pkg::CFG_W-1:0] cfg_data,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  operation,
    input logic [ADDR_BITS-1:0]        address,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        hit,
    input logic [WAY_W-1:0]            way,
    input logic                        writeback,
    input logic [sacts_pkg::CNT_W-1:0] dirty_count
);

    `SACTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `SACTS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    `SACTS_ASSERT_NOW(a_flush_fields, out_valid && (dirty_count != '0),
        !hit && (way == '0) && !writeback)
    `SACTS_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !writeback && (dirty_count == '0))

endmodule

bind set_assoc_cache_tag_store sacts_checker
#(
    .ADDR_BITS (ADDR_BITS),
    .WAY_W     (WAY_W)
)
u_sacts_checker (.*);

[sim/tag_store_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tag store checker
// Watches the configuration port and the request and result channels of the tag store,
// keeps its own copy of the line state to predict every result, and compares
// each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tag_store_checker
    import sacts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       operation,
    input  logic [31:0]      address,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic             hit,
    input  logic [2:0]       way,
    input  logic             writeback,
    input  logic [CNT_W-1:0] dirty_count,
    output int               errors,
    output int               pending,
    output int               checked
);

    typedef struct packed {
        logic             hit;
        logic [2:0]       way;
        logic             writeback;
        logic [CNT_W-1:0] dirty_count;
    } access_result_t;

    bit        line_valid [2048];
    bit        line_dirty [2048];
    bit [31:0] line_tag   [2048];
    bit [2:0]  line_order [2048];
    bit [2:0]  fill_level [256];

    bit       repl_lru;
    bit [3:0] offset_cfg;
    bit [3:0] sets_cfg;
    bit [3:0] ways_cfg;

    access_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic void promote(int base, int n, int w, bit [2:0] top);
        bit [2:0] mine;
        mine = line_order[base + w];
        for (int j = 0; j < n; j++)
        begin
            if (line_order[base + j] > mine)
                line_order[base + j]--;
        end
        line_order[base + w] = top;
    endfunction

    function automatic access_result_t access_cache(bit [1:0] op, bit [31:0] addr);
        access_result_t r;
        int n;
        int sb;
        int base;
        int set_idx;
        int w;
        int v;
        bit found;
        bit [31:0] blk;
        bit [31:0] tag;
        r = '0;
        n = (ways_cfg == 0) ? 1 : ((ways_cfg > 8) ? 8 : ways_cfg);
        sb = (sets_cfg > 8) ? 8 : sets_cfg;
        blk = addr >> offset_cfg;
        set_idx = blk & ((32'd1 << sb) - 1);
        tag = blk >> sb;
        base = set_idx * 8;
        found = 0;
        if (op == OP_FLUSH)
        begin
            for (int s = 0; s < (1 << sb); s++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (line_dirty[s * 8 + j])
                        r.dirty_count++;
                end
            end
            return r;
        end
        for (w = 0; w < n; w++)
        begin
            if (line_valid[base + w] && line_tag[base + w] == tag)
            begin
                found = 1;
                break;
            end
        end
        if (found)
        begin
            r.hit = 1;
            r.way = 3'(w);
            if (repl_lru)
                promote(base, n, w, fill_level[set_idx]);
            if (op == OP_WRITE)
                line_dirty[base + w] = 1;
        end
        else
        begin
            v = 0;
            for (int j = 0; j < n; j++)
            begin
                if (line_order[base + j] == 0)
                begin
                    v = j;
                    break;
                end
            end
            r.way = 3'(v);
            r.writeback = line_dirty[base + v];
            line_valid[base + v] = 1;
            line_tag[base + v] = tag;
            if (int'(fill_level[set_idx]) + 1 < n)
            begin
                fill_level[set_idx]++;
                line_order[base + v] = fill_level[set_idx];
            end
            else if (!repl_lru)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (line_order[base + j] > 0)
                        line_order[base + j]--;
                end
                line_order[base + v] = fill_level[set_idx];
            end
            else
            begin
                promote(base, n, v, fill_level[set_idx]);
            end
            line_dirty[base + v] = (op == OP_WRITE);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 2048; i++)
            begin
                line_valid[i] = 0;
                line_dirty[i] = 0;
                line_tag[i] = 0;
                line_order[i] = 0;
            end
            for (int i = 0; i < 256; i++)
                fill_level[i] = 0;
            repl_lru = RST_POLICY;
            offset_cfg = RST_OFFSET;
            sets_cfg = RST_SETS;
            ways_cfg = RST_WAYS;
            expected_results.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_POLICY: repl_lru = cfg_data[0];
                    REG_OFFSET: offset_cfg = cfg_data;
                    REG_SETS:   sets_cfg = cfg_data;
                    REG_WAYS:   ways_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.push_back(access_cache(operation, address));
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit expected %0d actual %0d", want.hit, hit);
                        errors++;
                    end
                    if (way !== want.way)
                    begin
                        $error("way expected %0d actual %0d", want.way, way);
                        errors++;
                    end
                    if (writeback !== want.writeback)
                    begin
                        $error("writeback expected %0d actual %0d", want.writeback, writeback);
                        errors++;
                    end
                    if (dirty_count !== want.dirty_count)
                    begin
                        $error("dirty_count expected %0d actual %0d",
                               want.dirty_count, dirty_count);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tag store testbench
// Drives directed and random cache requests through a series of cache
// geometries and replacement policies, with random request gaps and output stalls.
// The checker predicts and compares every result; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import sacts_pkg::*;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_write = 0;
    logic [IDX_W-1:0] cfg_index = REG_POLICY;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 0;
    logic             in_stall;
    logic [1:0]       operation = OP_READ;
    logic [31:0]      address = '0;
    logic             out_valid;
    logic             out_stall = 0;
    logic             hit;
    logic [2:0]       way;
    logic             writeback;
    logic [CNT_W-1:0] dirty_count;

    int errors;
    int pending;
    int checked;
    int idle_cycles = 0;
    int sent = 0;
    bit quiet = 0;
    bit [3:0] offset_now = RST_OFFSET;
    bit [3:0] sets_now = RST_SETS;
    bit [3:0] ways_now = RST_WAYS;

    bit [3:0] phase_cfg [12][4] = '{
        '{1, 0, 0, 1},  '{0, 12, 8, 8}, '{1, 4, 2, 4},  '{0, 3, 1, 2},
        '{1, 2, 3, 3},  '{0, 6, 4, 5},  '{1, 7, 8, 6},  '{0, 1, 5, 7},
        '{1, 12, 15, 0}, '{0, 9, 9, 15}, '{1, 5, 2, 8}, '{0, 0, 6, 3}
    };

    always #5 clk = ~clk;

    set_assoc_cache_tag_store i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .address(address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .way(way), .writeback(writeback), .dirty_count(dirty_count)
    );

    tag_store_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .address(address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .way(way), .writeback(writeback), .dirty_count(dirty_count),
        .errors(errors), .pending(pending), .checked(checked)
    );

    always
    begin
        @(negedge clk);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1;
            repeat ($urandom_range(1, 18)) @(negedge clk);
            out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_request(bit [1:0] op, bit [31:0] addr);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat ($urandom_range(0, 17)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1;
        operation <= op;
        address <= addr;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, bit [3:0] data);
        @(negedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 0;
    endtask

    function automatic bit [31:0] pick_address();
        int sb;
        bit [31:0] tag;
        bit [31:0] set_idx;
        bit [31:0] offs;
        if ($urandom_range(0, 6) == 0)
            return $urandom;
        sb = (sets_now > 8) ? 8 : sets_now;
        tag = $urandom_range(0, ((ways_now == 0) ? 1 : ways_now) + 3);
        if ($urandom_range(0, 9) == 0)
            tag = tag | ($urandom << 4);
        set_idx = $urandom & ((32'd1 << sb) - 1);
        offs = $urandom & ((32'd1 << offset_now) - 1);
        return (tag << (offset_now + sb)) | (set_idx << offset_now) | offs;
    endfunction

    function automatic bit [1:0] pick_operation();
        int r;
        r = $urandom_range(0, 39);
        if (r < 2)
            return OP_FLUSH;
        else if (r < 16)
            return OP_WRITE;
        else if (r < 21)
            return OP_FETCH;
        return OP_READ;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        send_request(OP_FLUSH, 32'h0000_0000);
        send_request(OP_READ, 32'h0000_0000);
        send_request(OP_WRITE, 32'hFFFF_FFFF);
        send_request(OP_FETCH, 32'h0000_001F);
        send_request(OP_WRITE, 32'h0000_0000);
        send_request(OP_FLUSH, 32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++)
            send_request(OP_WRITE, i * 32'h40);
        send_request(OP_READ, 32'h0000_0040);
        send_request(OP_FETCH, 32'hFFFF_FFE0);
        send_request(OP_FLUSH, 32'h1234_5678);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            write_reg(REG_POLICY, phase_cfg[p][0]);
            write_reg(REG_OFFSET, phase_cfg[p][1]);
            write_reg(REG_SETS, phase_cfg[p][2]);
            write_reg(REG_WAYS, phase_cfg[p][3]);
            offset_now = phase_cfg[p][1];
            sets_now = phase_cfg[p][2];
            ways_now = phase_cfg[p][3];
            quiet = (p == 11);
            for (int i = 0; i < 160; i++)
                send_request(pick_operation(), pick_address());
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d requests and %0d results over 13 cache configurations.",
                 sent, checked);
        if (errors == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
